FILE: design/pqa_pkg.sv
package pqa_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAX_PORTS = 16;

	localparam int PORT_W    = $clog2(MAX_PORTS);
	localparam int CNT_W     = PORT_W + 1;
	localparam int ICOUNT_W  = 5;
	localparam int MASK_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam int QB        = DATA_W - 1;
	localparam int QCNT_W    = $clog2(QB + 1);
	localparam int PROD_W    = 2 * DATA_W;
	localparam int DW        = DATA_W + FRAC_BITS;

	localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_MASK    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SUBSTITUTE = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_MULSAT,
		ST_DIVCHK,
		ST_DIV,
		ST_DIVEND,
		ST_FIN
	} pqa_state_t;

	typedef enum logic [1:0] {
		RUN_HOLD,
		RUN_MUL,
		RUN_DIV,
		RUN_OVF
	} pqa_run_t;

	typedef struct packed {
		logic     capture;
		logic     prep;
		logic     set_err;
		logic     mul;
		logic     div_init;
		logic     div_step;
		pqa_run_t run_sel;
		logic     advance;
		logic     emit;
	} pqa_cmd_t;

	typedef struct packed {
		logic err_seen;
		logic divide;
		logic div_zero;
		logic div_ovf;
		logic div_last;
		logic last;
		logic out_free;
	} pqa_status_t;

endpackage

FILE: design/pqa_controller.sv
module pqa_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  pqa_pkg::pqa_status_t st,
	output pqa_pkg::pqa_cmd_t    cmd
);
	import pqa_pkg::*;

	pqa_state_t state_q;
	pqa_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		item_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (st.err_seen) begin
					state_nxt = ST_FIN;
				end else if (st.divide && st.div_zero) begin
					cmd.set_err = 1'b1;
					state_nxt   = ST_FIN;
				end else begin
					cmd.prep  = 1'b1;
					state_nxt = st.divide ? ST_DIVCHK : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_MULSAT;
			end
			ST_MULSAT: begin
				cmd.run_sel = RUN_MUL;
				state_nxt   = ST_FIN;
			end
			ST_DIVCHK: begin
				if (st.div_ovf) begin
					cmd.run_sel = RUN_OVF;
					state_nxt   = ST_FIN;
				end else begin
					cmd.div_init = 1'b1;
					state_nxt    = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_nxt = ST_DIVEND;
				end
			end
			ST_DIVEND: begin
				cmd.run_sel = RUN_DIV;
				state_nxt   = ST_FIN;
			end
			ST_FIN: begin
				if (!st.last) begin
					cmd.advance = 1'b1;
					state_nxt   = ST_IDLE;
				end else if (st.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/pqa_datapath.sv
module pqa_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pqa_pkg::pqa_cmd_t                    cmd,
	output pqa_pkg::pqa_status_t                 st,
	input  logic signed [pqa_pkg::DATA_W-1:0]    operand,
	input  logic                                 last,
	input  logic                                 cfg_we,
	input  logic        [pqa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pqa_pkg::DATA_W-1:0]    cfg_data,
	input  logic                                 result_stall,
	output logic                                 result_valid,
	output logic signed [pqa_pkg::DATA_W-1:0]    product,
	output logic                                 error
);
	import pqa_pkg::*;

	function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] nv;
		nv = -v;
		return v[DATA_W-1] ? unsigned'(nv) : unsigned'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat(input logic [QB-1:0] m,
		input logic ovf, input logic neg);
		logic signed [DATA_W-1:0] pos;
		pos = $signed({1'b0, m});
		if (ovf) begin
			return neg ? $signed(S_MIN) : $signed(S_MAX);
		end
		return neg ? -pos : pos;
	endfunction

	logic        [ICOUNT_W-1:0]  icount_q;
	logic        [MASK_W-1:0]    mask_q;
	logic signed [DATA_W-1:0]    zsub_q;

	logic signed [DATA_W-1:0]    running_q;
	logic        [PORT_W-1:0]    pidx_q;
	logic                        err_q;

	logic signed [DATA_W-1:0]    op_q;
	logic                        last_q;
	logic        [DATA_W-1:0]    a_mag_q;
	logic        [DATA_W-1:0]    b_mag_q;
	logic                        neg_q;
	logic        [PROD_W-1:0]    prod_q;
	logic        [QB-1:0]        rem_q;
	logic        [QB-1:0]        dsh_q;
	logic        [QB-1:0]        quo_q;
	logic        [QCNT_W-1:0]    cnt_q;

	logic                        result_valid_q;
	logic signed [DATA_W-1:0]    product_q;
	logic                        error_q;

	logic        [CNT_W-1:0]     nports;
	logic                        divide;
	logic signed [DATA_W-1:0]    eff;
	logic        [DW-1:0]        dwide;
	logic        [DW-DATA_W:0]   r0;
	logic                        mul_ovf;
	logic        [QB-1:0]        mul_m;
	logic        [DATA_W-1:0]    trial;
	logic                        ge;
	logic        [CNT_W-1:0]     pidx_inc;
	logic        [PORT_W-1:0]    pidx_nxt;
	logic                        out_free;

	always_comb begin
		if (icount_q == '0) begin
			nports = CNT_W'(1);
		end else if (icount_q > ICOUNT_W'(MAX_PORTS)) begin
			nports = CNT_W'(MAX_PORTS);
		end else begin
			nports = CNT_W'(icount_q);
		end
	end

	assign divide   = (nports > CNT_W'(1)) && mask_q[pidx_q];
	assign eff      = (divide && op_q == '0) ? zsub_q : op_q;
	assign dwide    = {a_mag_q, {FRAC_BITS{1'b0}}};
	assign r0       = dwide[DW-1:DATA_W-1];
	assign mul_ovf  = |prod_q[PROD_W-1:FRAC_BITS+DATA_W-1];
	assign mul_m    = prod_q[FRAC_BITS+DATA_W-2:FRAC_BITS];
	assign trial    = {rem_q, dsh_q[QB-1]};
	assign ge       = trial >= b_mag_q;
	assign pidx_inc = CNT_W'(pidx_q) + CNT_W'(1);
	assign pidx_nxt = (nports > CNT_W'(1) && pidx_inc < nports) ? pidx_inc[PORT_W-1:0] : '0;
	assign out_free = !result_valid_q || !result_stall;

	assign st.err_seen = err_q;
	assign st.divide   = divide;
	assign st.div_zero = (op_q == '0) && (zsub_q == '0);
	assign st.div_ovf  = DATA_W'(r0) >= b_mag_q;
	assign st.div_last = (cnt_q == QCNT_W'(1));
	assign st.last     = last_q;
	assign st.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icount_q <= ICOUNT_W'(1);
			mask_q   <= '0;
			zsub_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_COUNT:     icount_q <= cfg_data[ICOUNT_W-1:0];
				REG_DIVIDE_MASK:     mask_q   <= cfg_data[MASK_W-1:0];
				REG_ZERO_SUBSTITUTE: zsub_q   <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= $signed(ONE_Q);
			pidx_q    <= '0;
			err_q     <= 1'b0;
		end else if (cmd.emit) begin
			running_q <= $signed(ONE_Q);
			pidx_q    <= '0;
			err_q     <= 1'b0;
		end else begin
			case (cmd.run_sel)
				RUN_MUL: running_q <= sat(mul_m, mul_ovf, neg_q);
				RUN_DIV: running_q <= sat(quo_q, 1'b0, neg_q);
				RUN_OVF: running_q <= sat('0, 1'b1, neg_q);
				default: begin
				end
			endcase
			if (cmd.set_err) begin
				err_q <= 1'b1;
			end
			if (cmd.advance) begin
				pidx_q <= pidx_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.capture) begin
				last_q <= last;
			end
			if (cmd.div_init) begin
				cnt_q <= QCNT_W'(QB);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operand;
		end
		if (cmd.prep) begin
			a_mag_q <= mag(running_q);
			b_mag_q <= mag(eff);
			neg_q   <= running_q[DATA_W-1] ^ eff[DATA_W-1];
		end
		if (cmd.mul) begin
			prod_q <= a_mag_q * b_mag_q;
		end
		if (cmd.div_init) begin
			rem_q <= QB'(r0);
			dsh_q <= dwide[QB-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? QB'(trial - b_mag_q) : QB'(trial);
			dsh_q <= {dsh_q[QB-2:0], 1'b0};
			quo_q <= {quo_q[QB-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			product_q <= err_q ? '0 : running_q;
			error_q   <= err_q;
		end
	end

	assign result_valid = result_valid_q;
	assign product      = product_q;
	assign error        = error_q;

endmodule

FILE: design/product_quotient_accumulator.sv
// Folds signed Q16.16 operands, one per beat, into a running value that starts
// at 1.0 and emits it, saturated, on the beat marked last (or zero with error
// set after an unresolved division by zero). One beat is taken at a time: a
// multiply goes through one registered 32x32 multiplier, then a saturation
// step, a divide through a restoring divider that retires one quotient bit
// per cycle for 31 quotient bits, a divide that would overflow saturates
// without dividing, and a beat that arrives after an error is skipped. A last
// beat also waits until the output register is free. Configuration is taken
// every cycle and must only be written while the block is idle.
module product_quotient_accumulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic signed [pqa_pkg::DATA_W-1:0]    operand,
	input  logic                                 last,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [pqa_pkg::DATA_W-1:0]    product,
	output logic                                 error,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [pqa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pqa_pkg::DATA_W-1:0]    cfg_data
);
	import pqa_pkg::*;

	pqa_cmd_t    cmd;
	pqa_status_t st;

	assign cfg_ready = 1'b1;

	pqa_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	pqa_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.operand      (operand),
		.last         (last),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.product      (product),
		.error        (error)
	);

endmodule

FILE: design/pqa_checker.sv
module pqa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_stall,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic signed [pqa_pkg::DATA_W-1:0] product,
	input logic                              error
);
	import pqa_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(product) && $stable(error))
		else $error("stalled result beat changed");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error |-> product == '0)
		else $error("error beat carries nonzero product");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall ##1 item_stall)
		else $error("input beat taken while previous beat in flight");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared in the cycle after an accept");

endmodule

bind product_quotient_accumulator pqa_checker u_pqa_checker (.*);

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pqa_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] product;
		logic                     error;
	} chain_result_t;

	class product_scoreboard;
		logic [ICOUNT_W-1:0]      input_count;
		logic [MASK_W-1:0]        divide_mask;
		logic signed [DATA_W-1:0] zero_substitute;
		logic signed [DATA_W-1:0] running_value;
		int unsigned              port_index;
		bit                       error_seen;
		chain_result_t            expected_products[$];
		int                       operands_seen;
		int                       chains_closed;
		int                       results_checked;
		int                       failures;

		function new();
			input_count = 1;
			divide_mask = '0;
			zero_substitute = '0;
			operands_seen = 0;
			chains_closed = 0;
			results_checked = 0;
			failures = 0;
			restart_chain();
		endfunction

		function void restart_chain();
			running_value = ONE_Q;
			port_index = 0;
			error_seen = 1'b0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] data);
			case (index)
				REG_INPUT_COUNT: input_count = data[ICOUNT_W-1:0];
				REG_DIVIDE_MASK: divide_mask = data[MASK_W-1:0];
				REG_ZERO_SUBSTITUTE: zero_substitute = data;
				default: ;
			endcase
		endfunction

		static function bit [63:0] magnitude(logic signed [DATA_W-1:0] v);
			return v[DATA_W-1] ? 64'(-longint'(v)) : 64'(v);
		endfunction

		static function logic signed [DATA_W-1:0] saturate(bit [63:0] m, bit neg);
			if (neg)
				return (m >= 64'h8000_0000) ? S_MIN : DATA_W'(-m);
			return (m > 64'h7FFF_FFFF) ? S_MAX : DATA_W'(m);
		endfunction

		static function logic signed [DATA_W-1:0] scaled_product(
				logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
			return saturate((magnitude(a) * magnitude(b)) >> FRAC_BITS,
				a[DATA_W-1] ^ b[DATA_W-1]);
		endfunction

		static function logic signed [DATA_W-1:0] scaled_quotient(
				logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
			return saturate((magnitude(a) << FRAC_BITS) / magnitude(b),
				a[DATA_W-1] ^ b[DATA_W-1]);
		endfunction

		function int unsigned active_ports();
			int unsigned n;
			n = 32'(input_count);
			if (n == 0)
				n = 1;
			if (n > MAX_PORTS)
				n = MAX_PORTS;
			return n;
		endfunction

		function void take_operand(logic signed [DATA_W-1:0] x, logic lst);
			int unsigned              n;
			bit                       divide;
			logic signed [DATA_W-1:0] divisor;
			chain_result_t            done;
			n = active_ports();
			operands_seen++;
			if (!error_seen) begin
				divide = (n > 1) && (port_index < MASK_W) && divide_mask[port_index];
				if (!divide) begin
					running_value = scaled_product(running_value, x);
				end else begin
					divisor = (x == 0) ? zero_substitute : x;
					if (divisor == 0)
						error_seen = 1'b1;
					else
						running_value = scaled_quotient(running_value, divisor);
				end
			end
			port_index = (n > 1 && port_index + 1 < n) ? port_index + 1 : 0;
			if (lst) begin
				done.product = error_seen ? '0 : running_value;
				done.error = error_seen;
				expected_products.push_back(done);
				chains_closed++;
				restart_chain();
			end
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			failures++;
		endtask

		task check_result(logic signed [DATA_W-1:0] p, logic e);
			chain_result_t want;
			if (expected_products.size() == 0) begin
				report($sformatf("result with no chain closed: product=%h error=%b", p, e));
				return;
			end
			want = expected_products.pop_front();
			results_checked++;
			if (p !== want.product)
				report($sformatf("result %0d product %h, expected %h", results_checked, p,
					want.product));
			if (e !== want.error)
				report($sformatf("result %0d error %b, expected %b", results_checked, e,
					want.error));
		endtask

		function int pending();
			return expected_products.size();
		endfunction
	endclass

	localparam int LIMIT       = 500000;
	localparam int SETTLE      = 48;
	localparam int ITEM_TARGET = 750;
	localparam int CALM_AFTER  = 660;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic signed [DATA_W-1:0] operand = '0;
	logic                     last = 1'b0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [DATA_W-1:0] product;
	logic                     error;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [DATA_W-1:0]        cfg_data = '0;

	product_scoreboard board = new();

	int items_sent = 0;
	int settings_used = 0;
	int idle_pct = 0;
	int stall_left = 0;
	int cycles;
	bit calm = 1'b0;

	product_quotient_accumulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operand      (operand),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.product      (product),
		.error        (error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (calm) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk)
		if (result_valid && !result_stall)
			board.check_result(product, error);

	task automatic send_beat(logic signed [DATA_W-1:0] op, logic lst);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		operand <= op;
		last <= lst;
		do @(posedge clk); while (item_stall);
		board.take_operand(op, lst);
		items_sent++;
		if (items_sent >= CALM_AFTER)
			calm = 1'b1;
	endtask

	// drop valid, drain every open chain, then let an in-flight divide finish
	task automatic settle();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(index, data);
	endtask

	task automatic configure(logic [ICOUNT_W-1:0] count, logic [MASK_W-1:0] mask,
			logic signed [DATA_W-1:0] subst);
		write_register(REG_INPUT_COUNT, DATA_W'(count));
		write_register(REG_DIVIDE_MASK, DATA_W'(mask));
		write_register(REG_ZERO_SUBSTITUTE, subst);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_operand();
		logic [DATA_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 11))
			0: return '0;
			1: begin
				case (r[1:0])
					2'd0: return S_MAX;
					2'd1: return S_MIN;
					2'd2: return 1;
					default: return -1;
				endcase
			end
			2, 3: return r;
			default: return {{14{r[18]}}, r[17:0]};
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_substitute();
		logic [DATA_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 5))
			0, 1: return '0;
			2: return S_MAX;
			3: return S_MIN;
			4: return {{14{r[18]}}, r[17:0]};
			default: return r;
		endcase
	endfunction

	function automatic logic [ICOUNT_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 16;
			3: return 17;
			4: return 31;
			default: return ICOUNT_W'($urandom_range(2, 5));
		endcase
	endfunction

	task automatic random_chain();
		int len;
		int n;
		n = board.active_ports();
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 2 * n + 2);
		for (int i = 0; i < len; i++)
			send_beat(pick_operand(), i == len - 1);
	endtask

	initial begin
		for (cycles = 0; cycles < LIMIT; cycles++)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int phase_items;
		int start;
		int pct;
		logic [MASK_W-1:0] mask;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 30;

		// reset settings: plain product, saturation both ways
		send_beat(S_MAX, 1'b0);
		send_beat(S_MAX, 1'b1);
		send_beat(S_MIN, 1'b0);
		send_beat(S_MAX, 1'b1);
		send_beat(S_MIN, 1'b1);
		send_beat('0, 1'b1);
		send_beat(-1, 1'b1);

		// two ports, second divides, zero divisor is an error
		settle();
		configure(5'd2, 16'h0002, '0);
		send_beat(32'sh0003_0000, 1'b0);
		send_beat('0, 1'b1);
		send_beat(32'sh0002_0000, 1'b0);
		send_beat('0, 1'b0);
		send_beat(32'sh0005_0000, 1'b0);
		send_beat(32'sh0007_0000, 1'b1);
		send_beat(S_MIN, 1'b0);
		send_beat(32'shFFFF_0000, 1'b1);
		send_beat(S_MAX, 1'b0);
		send_beat(32'sh0000_0001, 1'b1);

		// zero count acts as one port: the mask is ignored
		settle();
		configure(5'd0, 16'hFFFF, 32'shFFFE_0000);
		send_beat(32'sh0002_0000, 1'b0);
		send_beat('0, 1'b1);

		// count above the port limit, zero divisor replaced
		settle();
		configure(5'd31, 16'hAAAA, S_MIN);
		send_beat('0, 1'b0);
		send_beat('0, 1'b1);
		send_beat(32'sh0002_0000, 1'b0);
		send_beat('0, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			settle();
			case ($urandom_range(0, 3))
				0: mask = '0;
				1: mask = '1;
				default: mask = MASK_W'($urandom);
			endcase
			configure(pick_count(), mask, pick_substitute());
			pct = $urandom_range(0, 2);
			idle_pct = (pct == 0) ? 0 : (pct == 1) ? 10 : 30;
			phase_items = $urandom_range(30, 80);
			start = items_sent;
			while (items_sent - start < phase_items && items_sent < ITEM_TARGET)
				random_chain();
		end

		settle();
		$display("%0d operands in %0d chains, %0d results checked", board.operands_seen,
			board.chains_closed, board.results_checked);
		$display("%0d register settings, port counts 0 to 31, with and without stalls",
			settings_used);
		if (board.failures == 0 && board.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
